// ===== rtl/core/scss_pkg.sv =====
// Shared types, register indexes and fixed-point sine for the scan steering score block.
package scss_pkg;

    localparam logic [63:0] INV_TWO_PI_Q32 = 64'h0000_0000_28BE_60DB;
    localparam logic [63:0] PI_HALF_Q30    = 64'd1686629713;
    localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_GAIN = 2'd0;
    localparam cfg_idx_t CFG_NEAR = 2'd1;
    localparam cfg_idx_t CFG_FAR  = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_BIN  = 9'b0_0000_0010,
        S_ADDR = 9'b0_0000_0100,
        S_DIV  = 9'b0_0000_1000,
        S_MUL  = 9'b0_0001_0000,
        S_ACC  = 9'b0_0010_0000,
        S_GAIN = 9'b0_0100_0000,
        S_BIAS = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } state_t;

    // Sine of a Q32 phase in turns, Q30 result, Taylor series to the 15th power.
    function automatic logic signed [63:0] sine_q30(input logic [31:0] phase);
        logic [63:0]        x;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        begin
            x = {34'd0, phase[29:0]};
            if (phase[30])
            begin
                x = ONE_Q30 - x;
            end
            a    = (x * PI_HALF_Q30) >> 30;
            a2   = (a * a) >> 30;
            term = a;
            sum  = signed'(a);
            term = ((term * a2) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = ((term * a2) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = ((term * a2) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = ((term * a2) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = ((term * a2) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = ((term * a2) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            term = ((term * a2) >> 30) / 64'd210;
            sum  = sum - signed'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > signed'(ONE_Q30))
            begin
                sum = signed'(ONE_Q30);
            end
            return phase[31] ? -sum : sum;
        end
    endfunction

endpackage

// ===== rtl/core/scan_collision_steer_score.sv =====
// Scan collision steering score: sequencer around one shared 64-bit adder.
//
// Input stream (s_*): one scan point per item, bearing and range in s_tdata,
// s_tlast marks the last point of a scan. Output stream (m_*): one item per
// scan, the steering term in m_tdata and the too-close flag in m_tuser.
// Config port: cfg_we/cfg_index/cfg_data write gain, near and far limits.
//
// All arithmetic runs through a single adder under a state machine:
// bin multiply, address clamp, restoring reciprocal divide, weight
// multiply, score add. A point that does not score skips these steps and
// leaves the sequencer idle. A last point adds the gain multiply, rounding
// and output load. s_tready is high only while the sequencer is idle.
//
// Reset clears score, warning, pending output and loads register defaults
// (gain 5, near 100, far 1000). A finished result waits in the output
// register; the next scan proceeds meanwhile and its result stalls in the
// output load step until m_tready frees the register.
module scan_collision_steer_score #(
    parameter int ANGLE_BINS       = 360,
    parameter int WEIGHT_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [15:0] bearing, [31:16] range_mm
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [39:0] steer_term
    output logic               m_tuser,   // [0] too_close
    input  logic               cfg_we,
    input  scss_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]        cfg_data
);

    import scss_pkg::*;

    localparam int BIN_W = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int ROM_W = WEIGHT_FRAC_BITS + 2;
    localparam int SH_W  = (WEIGHT_FRAC_BITS + 1 > 16) ? WEIGHT_FRAC_BITS + 1 : 16;

    localparam logic [63:0]      BIN_SCALE = 64'(ANGLE_BINS) * INV_TWO_PI_Q32;
    localparam logic [18:0]      BIN_LIMIT = 19'(ANGLE_BINS - 1);
    localparam logic [BIN_W-1:0] BIN_MAX   = BIN_W'(ANGLE_BINS - 1);
    localparam logic [5:0]       BIN_LAST  = 6'd15;
    localparam logic [5:0]       DIV_LAST  = 6'd32;
    localparam logic [5:0]       MUL_LAST  = 6'(WEIGHT_FRAC_BITS);
    localparam logic [5:0]       GAIN_LAST = 6'd7;
    localparam logic [63:0]      RND_BIAS  = 64'h0000_0000_0000_FFFF;

    // weight table entry: {negative, magnitude}
    function automatic logic [ROM_W-1:0] rom_entry(input int idx);
        logic [63:0]               phase;
        logic signed [63:0]        s;
        logic signed [63:0]        sa;
        logic signed [63:0]        mag0;
        logic signed [63:0]        lim;
        logic                      neg;
        logic [WEIGHT_FRAC_BITS:0] mag;
        begin
            if (!((4 * idx < ANGLE_BINS) || (4 * idx > 3 * ANGLE_BINS)))
            begin
                return '0;
            end
            phase = (64'((2 * idx) % ANGLE_BINS) << 32) / ANGLE_BINS;
            s     = sine_q30(phase[31:0]);
            sa    = (s < 0) ? -s : s;
            mag0  = (sa + (64'sd1 <<< (29 - WEIGHT_FRAC_BITS))) >>> (30 - WEIGHT_FRAC_BITS);
            lim   = 64'sd1 <<< WEIGHT_FRAC_BITS;
            if (s < 0)
            begin
                neg = 1'b0;
                if (mag0 > lim - 1)
                begin
                    mag0 = lim - 1;
                end
            end
            else
            begin
                neg = 1'b1;
                if (mag0 > lim)
                begin
                    mag0 = lim;
                end
            end
            mag = mag0[WEIGHT_FRAC_BITS:0];
            return {neg, mag};
        end
    endfunction

    logic [ROM_W-1:0] rom_word [ANGLE_BINS];

    for (genvar g = 0; g < ANGLE_BINS; g++)
    begin : g_rom
        assign rom_word[g] = rom_entry(g);
    end

    state_t             state_reg,     state_next;
    logic [5:0]         cnt_reg,       cnt_next;
    logic [63:0]        acc_reg,       acc_next;
    logic [32:0]        quot_reg,      quot_next;
    logic [SH_W-1:0]    sh_reg,        sh_next;
    logic [15:0]        range_reg,     range_next;
    logic               final_reg,     final_next;
    logic [BIN_W-1:0]   bin_reg,       bin_next;
    logic [ROM_W-1:0]   rom_q_reg;
    logic signed [47:0] score_reg,     score_next;
    logic               warn_reg,      warn_next;
    logic [7:0]         gain_reg,      gain_next;
    logic [15:0]        near_reg,      near_next;
    logic [15:0]        far_reg,       far_next;
    logic               out_valid_reg, out_valid_next;
    logic [39:0]        steer_reg,     steer_next;
    logic               close_reg,     close_next;

    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        add_c;
    logic [63:0] add_sum;
    logic [15:0] in_range;
    logic        contrib;
    logic        div_ge;
    logic [63:0] term;
    logic        term_neg;
    logic [63:0] score_ext;
    logic        sat_hi;
    logic        sat_lo;

    assign in_range  = s_tdata[31:16];
    assign contrib   = (in_range != 16'd0) && (in_range < far_reg);
    assign term      = acc_reg >> WEIGHT_FRAC_BITS;
    assign term_neg  = rom_q_reg[ROM_W-1];
    assign score_ext = {{16{score_reg[47]}}, score_reg};

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_c = 1'b0;
        case (state_reg)
            S_BIN:
            begin
                add_a = acc_reg << 1;
                add_b = sh_reg[SH_W-1] ? BIN_SCALE : '0;
            end
            S_DIV:
            begin
                add_a = {47'd0, acc_reg[15:0], (cnt_reg == 6'd0)};
                add_b = ~{48'd0, range_reg};
                add_c = 1'b1;
            end
            S_MUL:
            begin
                add_a = acc_reg << 1;
                add_b = sh_reg[SH_W-1] ? {31'd0, quot_reg} : '0;
            end
            S_ACC:
            begin
                add_a = score_ext;
                add_b = term_neg ? ~term : term;
                add_c = term_neg;
            end
            S_GAIN:
            begin
                add_a = acc_reg << 1;
                add_b = sh_reg[SH_W-1] ? ~score_ext : '0;
                add_c = sh_reg[SH_W-1];
            end
            S_BIAS:
            begin
                add_a = acc_reg;
                add_b = acc_reg[63] ? RND_BIAS : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign add_sum = add_a + add_b + 64'(add_c);
    assign div_ge  = !add_sum[63];
    assign sat_hi  = !add_sum[63] && (add_sum[62:47] != 16'h0000);
    assign sat_lo  = add_sum[63] && (add_sum[62:47] != 16'hFFFF);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        quot_next      = quot_reg;
        sh_next        = sh_reg;
        range_next     = range_reg;
        final_next     = final_reg;
        bin_next       = bin_reg;
        score_next     = score_reg;
        warn_next      = warn_reg;
        gain_next      = gain_reg;
        near_next      = near_reg;
        far_next       = far_reg;
        out_valid_next = out_valid_reg && !m_tready;
        steer_next     = steer_reg;
        close_next     = close_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN: gain_next = cfg_data[7:0];
                CFG_NEAR: near_next = cfg_data;
                CFG_FAR:  far_next  = cfg_data;
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    range_next = in_range;
                    final_next = s_tlast;
                    acc_next   = '0;
                    cnt_next   = '0;
                    warn_next  = warn_reg || (in_range < near_reg);
                    if (contrib)
                    begin
                        sh_next    = SH_W'(s_tdata[15:0]) << (SH_W - 16);
                        state_next = S_BIN;
                    end
                    else if (s_tlast)
                    begin
                        sh_next    = SH_W'(gain_reg) << (SH_W - 8);
                        state_next = S_GAIN;
                    end
                end
            end
            S_BIN:
            begin
                acc_next = add_sum;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == BIN_LAST)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                bin_next   = (acc_reg[63:45] > BIN_LIMIT) ? BIN_MAX : acc_reg[45 +: BIN_W];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                acc_next  = div_ge ? add_sum : add_a;
                quot_next = {quot_reg[31:0], div_ge};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    sh_next    = SH_W'(rom_q_reg[WEIGHT_FRAC_BITS:0])
                                 << (SH_W - WEIGHT_FRAC_BITS - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = add_sum;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                score_next = sat_hi ? 48'sh7FFF_FFFF_FFFF :
                             sat_lo ? 48'sh8000_0000_0000 : signed'(add_sum[47:0]);
                if (final_reg)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    sh_next    = SH_W'(gain_reg) << (SH_W - 8);
                    state_next = S_GAIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GAIN:
            begin
                acc_next = add_sum;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == GAIN_LAST)
                begin
                    state_next = S_BIAS;
                end
            end
            S_BIAS:
            begin
                acc_next   = add_sum;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    steer_next     = acc_reg[55:16];
                    close_next     = warn_reg;
                    score_next     = '0;
                    warn_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            score_reg     <= '0;
            warn_reg      <= 1'b0;
            gain_reg      <= 8'd5;
            near_reg      <= 16'd100;
            far_reg       <= 16'd1000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            score_reg     <= score_next;
            warn_reg      <= warn_next;
            gain_reg      <= gain_next;
            near_reg      <= near_next;
            far_reg       <= far_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        sh_reg    <= sh_next;
        range_reg <= range_next;
        final_reg <= final_next;
        bin_reg   <= bin_next;
        rom_q_reg <= rom_word[bin_reg];
        steer_reg <= steer_next;
        close_reg <= close_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = steer_reg;
    assign m_tuser  = close_reg;

    a_skip_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !contrib && !s_tlast) |=> s_tready)
        else $error("non-scoring point did not return to idle");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside output step");

    a_bin_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (bin_reg <= BIN_MAX))
        else $error("bin out of table range");

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || m_tready))
        |=> (score_reg == 48'sd0 && !warn_reg && m_tvalid))
        else $error("scan state not cleared after result");

endmodule
